// ===== rtl/core/dcf_pkg.sv =====
// Shared types, codes and tables for the DCF77 time code decoder.
package dcf_pkg;

  typedef logic [2:0] pulse_ev_t;

  localparam pulse_ev_t EV_NONE    = 3'd0;
  localparam pulse_ev_t EV_SECOND  = 3'd1;
  localparam pulse_ev_t EV_MINUTE  = 3'd2;
  localparam pulse_ev_t EV_ZERO    = 3'd3;
  localparam pulse_ev_t EV_ONE     = 3'd4;
  localparam pulse_ev_t EV_INVALID = 3'd5;

  // Pulse timing windows in milliseconds.
  localparam logic [15:0] SEC_MIN  = 16'd900;
  localparam logic [15:0] SEC_MAX  = 16'd1100;
  localparam logic [15:0] MIN_MIN  = 16'd1900;
  localparam logic [15:0] MIN_MAX  = 16'd2100;
  localparam logic [15:0] ZERO_MIN = 16'd70;
  localparam logic [15:0] ZERO_MAX = 16'd130;
  localparam logic [15:0] ONE_MIN  = 16'd170;
  localparam logic [15:0] ONE_MAX  = 16'd230;
  localparam logic [7:0]  QUIET_MAX = 8'd220;

  localparam logic [11:0] YEAR_BASE = 12'd2000;

  // Frame bit positions.
  localparam logic [7:0] BIT_START_ZERO = 8'd0;
  localparam logic [7:0] BIT_CEST       = 8'd17;
  localparam logic [7:0] BIT_CET        = 8'd18;
  localparam logic [7:0] BIT_INFO_LAST  = 8'd19;
  localparam logic [7:0] BIT_MIN_BASE   = 8'd21;
  localparam logic [7:0] BIT_MIN_PAR    = 8'd28;
  localparam logic [7:0] BIT_HOUR_BASE  = 8'd29;
  localparam logic [7:0] BIT_HOUR_PAR   = 8'd35;
  localparam logic [7:0] BIT_DAY_BASE   = 8'd36;
  localparam logic [7:0] BIT_DAY_LAST   = 8'd41;
  localparam logic [7:0] BIT_WDAY_BASE  = 8'd42;
  localparam logic [7:0] BIT_WDAY_LAST  = 8'd44;
  localparam logic [7:0] BIT_MON_BASE   = 8'd45;
  localparam logic [7:0] BIT_MON_LAST   = 8'd49;
  localparam logic [7:0] BIT_YEAR_BASE  = 8'd50;
  localparam logic [7:0] BIT_DATE_PAR   = 8'd58;

  localparam logic [6:0] BCD_W [8] = '{7'd1, 7'd2, 7'd4, 7'd8, 7'd10, 7'd20, 7'd40, 7'd80};

  typedef struct packed {
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  month_day;
    logic [2:0]  week_day;
    logic [4:0]  month;
    logic [11:0] year;
    logic [1:0]  utc_offset;
  } clock_t;

  function automatic logic [6:0] bcd_weight(input logic b, input logic [2:0] pos);
    return b ? BCD_W[pos] : 7'd0;
  endfunction

endpackage

// ===== rtl/core/dcf_pulse_class.sv =====
// Edge timing classifier: turns level samples into second, minute, bit or invalid events.
module dcf_pulse_class import dcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        level_i,
  input  logic [15:0] time_ms_i,
  output pulse_ev_t   event_o
);

  logic        prev_level_q, prev_level_d;
  logic [15:0] fall_time_q, fall_time_d;
  logic [7:0]  quiet_q, quiet_d;
  logic [15:0] delta;

  assign delta = time_ms_i - fall_time_q;

  always_comb begin
    prev_level_d = prev_level_q;
    fall_time_d  = fall_time_q;
    quiet_d      = quiet_q;
    event_o      = EV_NONE;
    if (level_i != prev_level_q) begin
      prev_level_d = level_i;
      quiet_d      = 8'd0;
      if (prev_level_q && !level_i) begin
        fall_time_d = time_ms_i;
        if (delta >= SEC_MIN && delta <= SEC_MAX) begin
          event_o = EV_SECOND;
        end else if (delta >= MIN_MIN && delta <= MIN_MAX) begin
          event_o = EV_MINUTE;
        end else begin
          event_o = EV_INVALID;
        end
      end else begin
        // Rising edge: the low time since the last falling edge encodes the bit.
        if (delta >= ZERO_MIN && delta <= ZERO_MAX) begin
          event_o = EV_ZERO;
        end else if (delta >= ONE_MIN && delta <= ONE_MAX) begin
          event_o = EV_ONE;
        end else begin
          event_o = EV_INVALID;
        end
      end
    end else if (quiet_q > QUIET_MAX) begin
      event_o = EV_INVALID;
    end else begin
      quiet_d = quiet_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      fall_time_q  <= 16'd0;
      quiet_q      <= 8'd0;
    end else if (en_i) begin
      prev_level_q <= prev_level_d;
      fall_time_q  <= fall_time_d;
      quiet_q      <= quiet_d;
    end
  end

endmodule

// ===== rtl/core/dcf_frame_dec.sv =====
// Frame decoder: collects bits, checks parities and loads the clock registers at a minute mark.
module dcf_frame_dec import dcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  pulse_ev_t event_i,
  output logic      loaded_o,
  output clock_t    clock_o
);

  localparam logic [2:0] PH_WAIT  = 3'd0;
  localparam logic [2:0] PH_INFO  = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_MIN   = 3'd3;
  localparam logic [2:0] PH_HOUR  = 3'd4;
  localparam logic [2:0] PH_DATE  = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] idx_q, idx_d;
  logic       par_q, par_d;
  logic       ok_q, ok_d;
  logic [2:0] info_q, info_d;
  logic [6:0] rx_min_q, rx_min_d;
  logic [5:0] rx_hour_q, rx_hour_d;
  logic [5:0] rx_day_q, rx_day_d;
  logic [2:0] rx_wday_q, rx_wday_d;
  logic [4:0] rx_mon_q, rx_mon_d;
  logic [7:0] rx_year_q, rx_year_d;
  logic [1:0] rx_ofs_q, rx_ofs_d;
  clock_t     clk_q, clk_d;

  logic       b;
  logic [7:0] off_min, off_hour, off_day, off_wday, off_mon, off_year;
  logic [6:0] w_min, w_hour, w_day, w_wday, w_mon, w_year;

  assign b        = (event_i == EV_ONE);
  assign off_min  = idx_q - BIT_MIN_BASE;
  assign off_hour = idx_q - BIT_HOUR_BASE;
  assign off_day  = idx_q - BIT_DAY_BASE;
  assign off_wday = idx_q - BIT_WDAY_BASE;
  assign off_mon  = idx_q - BIT_MON_BASE;
  assign off_year = idx_q - BIT_YEAR_BASE;
  assign w_min    = bcd_weight(b, off_min[2:0]);
  assign w_hour   = bcd_weight(b, off_hour[2:0]);
  assign w_day    = bcd_weight(b, off_day[2:0]);
  assign w_wday   = bcd_weight(b, off_wday[2:0]);
  assign w_mon    = bcd_weight(b, off_mon[2:0]);
  assign w_year   = bcd_weight(b, off_year[2:0]);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    par_d     = par_q;
    ok_d      = ok_q;
    info_d    = info_q;
    rx_min_d  = rx_min_q;
    rx_hour_d = rx_hour_q;
    rx_day_d  = rx_day_q;
    rx_wday_d = rx_wday_q;
    rx_mon_d  = rx_mon_q;
    rx_year_d = rx_year_q;
    rx_ofs_d  = rx_ofs_q;
    clk_d     = clk_q;
    loaded_o  = 1'b0;

    if (event_i == EV_MINUTE) begin
      if (ok_q) begin
        clk_d.year       = YEAR_BASE + {4'd0, rx_year_q};
        clk_d.month      = rx_mon_q;
        clk_d.month_day  = rx_day_q;
        clk_d.week_day   = rx_wday_q;
        clk_d.hour       = rx_hour_q;
        clk_d.minute     = rx_min_q;
        clk_d.utc_offset = rx_ofs_q;
        loaded_o         = 1'b1;
      end
      par_d     = 1'b0;
      idx_d     = 8'd0;
      ok_d      = 1'b0;
      rx_min_d  = 7'd0;
      rx_hour_d = 6'd0;
      rx_day_d  = 6'd0;
      rx_wday_d = 3'd0;
      rx_mon_d  = 5'd0;
      rx_year_d = 8'd0;
      phase_d   = PH_INFO;
    end else if (event_i == EV_INVALID) begin
      ok_d    = 1'b0;
      phase_d = PH_WAIT;
    end else if (event_i == EV_ZERO || event_i == EV_ONE) begin
      unique case (phase_q)
        PH_INFO: begin
          if (idx_q == BIT_START_ZERO) info_d[0] = b;
          else if (idx_q == BIT_CEST) info_d[1] = b;
          else if (idx_q == BIT_CET) info_d[2] = b;
          if (idx_q >= BIT_INFO_LAST) begin
            if (info_d[0]) begin
              phase_d = PH_WAIT;
            end else begin
              // Unknown zone bit combinations keep the previous offset.
              if (info_d[2:1] == 2'b10) rx_ofs_d = 2'd1;
              else if (info_d[2:1] == 2'b01) rx_ofs_d = 2'd2;
              phase_d = PH_START;
            end
          end
        end
        PH_START: begin
          phase_d = b ? PH_MIN : PH_WAIT;
        end
        PH_MIN: begin
          if (idx_q >= BIT_MIN_PAR) begin
            if (par_q != b) begin
              phase_d = PH_WAIT;
            end else begin
              par_d   = 1'b0;
              phase_d = PH_HOUR;
            end
          end else begin
            par_d    = par_q ^ b;
            rx_min_d = rx_min_q + w_min;
          end
        end
        PH_HOUR: begin
          if (idx_q >= BIT_HOUR_PAR) begin
            if (par_q != b) begin
              phase_d = PH_WAIT;
            end else begin
              par_d   = 1'b0;
              phase_d = PH_DATE;
            end
          end else begin
            par_d     = par_q ^ b;
            rx_hour_d = rx_hour_q + w_hour[5:0];
          end
        end
        PH_DATE: begin
          if (idx_q >= BIT_DATE_PAR) begin
            phase_d = PH_WAIT;
            ok_d    = (par_q == b);
          end else begin
            par_d = par_q ^ b;
            if (idx_q <= BIT_DAY_LAST) rx_day_d = rx_day_q + w_day[5:0];
            else if (idx_q <= BIT_WDAY_LAST) rx_wday_d = rx_wday_q + w_wday[2:0];
            else if (idx_q <= BIT_MON_LAST) rx_mon_d = rx_mon_q + w_mon[4:0];
            else rx_year_d = rx_year_q + {1'b0, w_year};
          end
        end
        default: begin
          // A bit outside a frame drops any frame that was waiting to load.
          ok_d    = 1'b0;
          phase_d = PH_WAIT;
        end
      endcase
      if (idx_q != 8'hFF) idx_d = idx_q + 8'd1;
    end
  end

  assign clock_o = clk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      idx_q     <= 8'd0;
      par_q     <= 1'b0;
      ok_q      <= 1'b0;
      info_q    <= 3'd0;
      rx_min_q  <= 7'd0;
      rx_hour_q <= 6'd0;
      rx_day_q  <= 6'd0;
      rx_wday_q <= 3'd0;
      rx_mon_q  <= 5'd0;
      rx_year_q <= 8'd0;
      rx_ofs_q  <= 2'd0;
      clk_q     <= '{minute: 7'd0, hour: 6'd0, month_day: 6'd1, week_day: 3'd7,
                     month: 5'd1, year: 12'd2017, utc_offset: 2'd2};
    end else if (en_i) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      par_q     <= par_d;
      ok_q      <= ok_d;
      info_q    <= info_d;
      rx_min_q  <= rx_min_d;
      rx_hour_q <= rx_hour_d;
      rx_day_q  <= rx_day_d;
      rx_wday_q <= rx_wday_d;
      rx_mon_q  <= rx_mon_d;
      rx_year_q <= rx_year_d;
      rx_ofs_q  <= rx_ofs_d;
      clk_q     <= clk_d;
    end
  end

endmodule

// ===== rtl/core/dcf77_time_code_decoder_core.sv =====
// Top level of the DCF77 time code decoder: input register, decoder logic, result register.
//
// Usage: present one sample tick (receiver level and 16-bit millisecond time)
// on the input channel for every 10 ms sample. Each accepted item produces
// exactly one result item: the pulse event of that tick, a flag that a
// validated frame was loaded, and the clock registers after any load.
// An accepted item is held in the input register; on the next cycle in which
// the result register is free or being emptied, the edge classifier and the
// frame decoder evaluate it in one pass and the result register captures it.
// While the receiver keeps taking results, one item can be
// accepted every cycle. The input register lets one more item be taken while
// a result waits; with both registers full, in_ready_o drops until the
// receiver takes the result. After reset both channels are empty, the
// decoder waits for a minute mark and the clock reads 00:00 on 1.1.2017,
// weekday 7, UTC offset 2.
module dcf77_time_code_decoder_core import dcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        signal_level_i,
  input  logic [15:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  pulse_event_o,
  output logic        clock_loaded_o,
  output logic [6:0]  minute_o,
  output logic [5:0]  hour_o,
  output logic [5:0]  month_day_o,
  output logic [2:0]  week_day_o,
  output logic [4:0]  month_o,
  output logic [11:0] year_o,
  output logic [1:0]  utc_offset_o
);

  logic        s1_valid_q, s1_valid_d;
  logic        s1_level_q;
  logic [15:0] s1_time_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        accept;
  pulse_ev_t   ev;
  logic        loaded;
  clock_t      clock_now;
  pulse_ev_t   ev_q;
  logic        loaded_q;
  clock_t      clock_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  dcf_pulse_class u_class (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .level_i   (s1_level_q),
    .time_ms_i (s1_time_q),
    .event_o   (ev)
  );

  dcf_frame_dec u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .event_i  (ev),
    .loaded_o (loaded),
    .clock_o  (clock_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_level_q <= signal_level_i;
      s1_time_q  <= time_ms_i;
    end
    if (advance) begin
      ev_q     <= ev;
      loaded_q <= loaded;
      clock_q  <= clock_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_event_o  = ev_q;
  assign clock_loaded_o = loaded_q;
  assign minute_o       = clock_q.minute;
  assign hour_o         = clock_q.hour;
  assign month_day_o    = clock_q.month_day;
  assign week_day_o     = clock_q.week_day;
  assign month_o        = clock_q.month;
  assign year_o         = clock_q.year;
  assign utc_offset_o   = clock_q.utc_offset;

`ifndef SYNTHESIS
  // A frame is only ever loaded on a minute mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clock_loaded_o) |-> (pulse_event_o == EV_MINUTE))
    else $error("clock loaded without a minute mark");

  // The year register always holds the base year plus an 8-bit value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= 12'd2000 && year_o <= 12'd2255))
    else $error("year out of range");

  // With both registers full and the result stalled, no item may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("item accepted while both stages are full");
`endif

endmodule

// ===== bench/dcf77_time_code_decoder_core_test.sv =====
// Self-checking testbench for the DCF77 time code decoder core: directed ticks, then framed traffic.
module dcf77_time_code_decoder_core_test import dcf_pkg::*; ();

  // Pulse timing windows in milliseconds.
  localparam logic [15:0] SECOND_LO = 16'd900;
  localparam logic [15:0] SECOND_HI = 16'd1100;
  localparam logic [15:0] MARK_LO   = 16'd1900;
  localparam logic [15:0] MARK_HI   = 16'd2100;
  localparam logic [15:0] ZERO_LO   = 16'd70;
  localparam logic [15:0] ZERO_HI   = 16'd130;
  localparam logic [15:0] ONE_LO    = 16'd170;
  localparam logic [15:0] ONE_HI    = 16'd230;
  localparam logic [7:0]  SILENCE_LIMIT = 8'd220;

  // Frame bit positions.
  localparam int START_BIT    = 0;
  localparam int CEST_BIT     = 17;
  localparam int CET_BIT      = 18;
  localparam int INFO_END     = 19;
  localparam int BEGIN_BIT    = 20;
  localparam int MIN_BASE     = 21;
  localparam int MIN_PAR_BIT  = 28;
  localparam int HOUR_BASE    = 29;
  localparam int HOUR_PAR_BIT = 35;
  localparam int DAY_BASE     = 36;
  localparam int DAY_END      = 41;
  localparam int WDAY_BASE    = 42;
  localparam int WDAY_END     = 44;
  localparam int MON_BASE     = 45;
  localparam int MON_END      = 49;
  localparam int YEAR_BASE_BIT = 50;
  localparam int DATE_PAR_BIT = 58;

  localparam logic [1:0] ZONE_CET  = 2'd1;
  localparam logic [1:0] ZONE_CEST = 2'd2;

  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic [2:0] {
    SEEK_MARK, READ_INFO, READ_START, READ_MINUTE, READ_HOUR, READ_DATE
  } frame_stage_e;

  typedef enum logic [3:0] {
    FR_GOOD, FR_START_SET, FR_BEGIN_CLEAR, FR_MIN_PAR, FR_HOUR_PAR, FR_DATE_PAR,
    FR_ZONE, FR_GLITCH, FR_SKIP, FR_EXTRA, FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    pulse_ev_t ev;
    logic      loaded;
    clock_t    wall;
  } tick_result_t;

  typedef struct packed {
    logic        lvl;
    logic [15:0] t;
    logic [7:0]  reps;
    logic        typed;
    pulse_ev_t   ev;
  } drill_row_t;

  localparam int DRILL_ROWS = 27;
  localparam drill_row_t DRILLS [DRILL_ROWS] = '{
    '{1'b0, 16'd0,     8'd1,   1'b1, EV_NONE},
    '{1'b1, 16'd100,   8'd1,   1'b1, EV_ZERO},
    '{1'b0, 16'd1000,  8'd1,   1'b1, EV_SECOND},
    '{1'b1, 16'd1200,  8'd1,   1'b1, EV_ONE},
    '{1'b0, 16'd1900,  8'd1,   1'b1, EV_SECOND},
    '{1'b1, 16'd1970,  8'd1,   1'b1, EV_ZERO},
    '{1'b0, 16'd3000,  8'd1,   1'b1, EV_SECOND},
    '{1'b1, 16'd3130,  8'd1,   1'b1, EV_ZERO},
    '{1'b0, 16'd4101,  8'd1,   1'b1, EV_INVALID},
    '{1'b1, 16'd4170,  8'd1,   1'b1, EV_INVALID},
    '{1'b0, 16'd6001,  8'd1,   1'b1, EV_MINUTE},
    '{1'b1, 16'd6171,  8'd1,   1'b1, EV_ONE},
    '{1'b0, 16'd8101,  8'd1,   1'b1, EV_MINUTE},
    '{1'b1, 16'd8331,  8'd1,   1'b1, EV_ONE},
    '{1'b0, 16'd9000,  8'd1,   1'b1, EV_INVALID},
    '{1'b1, 16'd9131,  8'd1,   1'b1, EV_INVALID},
    '{1'b1, 16'd9140,  8'd1,   1'b1, EV_NONE},
    '{1'b0, 16'd10899, 8'd1,   1'b1, EV_INVALID},
    '{1'b1, 16'd11130, 8'd1,   1'b1, EV_INVALID},
    '{1'b0, 16'd13000, 8'd1,   1'b1, EV_INVALID},
    '{1'b1, 16'd13169, 8'd1,   1'b1, EV_INVALID},
    '{1'b0, 16'd65000, 8'd1,   1'b0, EV_NONE},
    '{1'b1, 16'd65100, 8'd1,   1'b0, EV_NONE},
    '{1'b0, 16'd464,   8'd1,   1'b0, EV_NONE},
    '{1'b1, 16'd664,   8'd1,   1'b0, EV_NONE},
    '{1'b0, 16'd65535, 8'd223, 1'b0, EV_NONE},
    '{1'b1, 16'd99,    8'd1,   1'b1, EV_ZERO}
  };

  localparam int CYCLE_LEN = 13;
  localparam frame_kind_e KIND_CYCLE [CYCLE_LEN] = '{
    FR_ZONE, FR_START_SET, FR_MIN_PAR, FR_GOOD, FR_ZONE, FR_HOUR_PAR, FR_DATE_PAR,
    FR_BEGIN_CLEAR, FR_GLITCH, FR_NOISE, FR_SKIP, FR_EXTRA, FR_GOOD
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        sig_level = 1'b0;
  logic [15:0] time_ms = 16'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  pulse_event;
  logic        clock_loaded;
  logic [6:0]  minute;
  logic [5:0]  hour;
  logic [5:0]  month_day;
  logic [2:0]  week_day;
  logic [4:0]  month;
  logic [11:0] year;
  logic [1:0]  utc_offset;

  dcf77_time_code_decoder_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .signal_level_i (sig_level),
    .time_ms_i      (time_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pulse_event_o  (pulse_event),
    .clock_loaded_o (clock_loaded),
    .minute_o       (minute),
    .hour_o         (hour),
    .month_day_o    (month_day),
    .week_day_o     (week_day),
    .month_o        (month),
    .year_o         (year),
    .utc_offset_o   (utc_offset)
  );

  // Decoder state as the predictor sees it.
  logic         line_lvl = 1'b0;
  logic [15:0]  last_fall = 16'd0;
  logic [7:0]   idle_ticks = 8'd0;
  frame_stage_e stage = SEEK_MARK;
  logic [7:0]   bit_pos = 8'd0;
  logic         par = 1'b0;
  logic         frame_good = 1'b0;
  logic [2:0]   info_flags = 3'd0;
  logic [6:0]   acc_min = 7'd0;
  logic [5:0]   acc_hour = 6'd0;
  logic [5:0]   acc_day = 6'd0;
  logic [2:0]   acc_wday = 3'd0;
  logic [4:0]   acc_mon = 5'd0;
  logic [7:0]   acc_year = 8'd0;
  logic [1:0]   acc_zone = 2'd0;
  clock_t       wall = '{minute: 7'd0, hour: 6'd0, month_day: 6'd1, week_day: 3'd7,
                         month: 5'd1, year: 12'd2017, utc_offset: 2'd2};

  tick_result_t pending_ticks [$];
  tick_result_t got_exp;

  // Sender's view of the line it is producing.
  logic        snd_lvl;
  logic [15:0] snd_fall;
  logic [15:0] snd_now;

  int  errors = 0;
  int  sent_items = 0;
  int  results_seen = 0;
  int  loads_seen = 0;
  int  invalid_seen = 0;
  int  frames_sent = 0;
  bit  calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("dcf77_time_code_decoder_core_test: done, errors");
    $finish;
  end

  function automatic logic [6:0] digit_weight(input logic b, input int pos);
    logic [6:0] w;
    case (pos & 7)
      0: w = 7'd1;
      1: w = 7'd2;
      2: w = 7'd4;
      3: w = 7'd8;
      4: w = 7'd10;
      5: w = 7'd20;
      6: w = 7'd40;
      default: w = 7'd80;
    endcase
    return b ? w : 7'd0;
  endfunction

  task automatic take_bit(input logic b);
    int i;
    i = bit_pos;
    case (stage)
      READ_INFO: begin
        if (i == START_BIT) info_flags[0] = b;
        else if (i == CEST_BIT) info_flags[1] = b;
        else if (i == CET_BIT) info_flags[2] = b;
        if (i >= INFO_END) begin
          if (info_flags[0]) begin
            stage = SEEK_MARK;
          end else begin
            // Only a clean CET or CEST pair updates the zone.
            if (info_flags[2:1] == 2'b10) acc_zone = ZONE_CET;
            else if (info_flags[2:1] == 2'b01) acc_zone = ZONE_CEST;
            stage = READ_START;
          end
        end
      end
      READ_START: stage = b ? READ_MINUTE : SEEK_MARK;
      READ_MINUTE: begin
        if (i >= MIN_PAR_BIT) begin
          if (par != b) stage = SEEK_MARK;
          else begin
            par = 1'b0;
            stage = READ_HOUR;
          end
        end else begin
          par ^= b;
          acc_min = 7'(acc_min + digit_weight(b, i - MIN_BASE));
        end
      end
      READ_HOUR: begin
        if (i >= HOUR_PAR_BIT) begin
          if (par != b) stage = SEEK_MARK;
          else begin
            par = 1'b0;
            stage = READ_DATE;
          end
        end else begin
          par ^= b;
          acc_hour = 6'(acc_hour + digit_weight(b, i - HOUR_BASE));
        end
      end
      READ_DATE: begin
        if (i >= DATE_PAR_BIT) begin
          stage = SEEK_MARK;
          frame_good = (par == b);
        end else begin
          par ^= b;
          if (i <= DAY_END) acc_day = 6'(acc_day + digit_weight(b, i - DAY_BASE));
          else if (i <= WDAY_END) acc_wday = 3'(acc_wday + digit_weight(b, i - WDAY_BASE));
          else if (i <= MON_END) acc_mon = 5'(acc_mon + digit_weight(b, i - MON_BASE));
          else acc_year = 8'(acc_year + digit_weight(b, i - YEAR_BASE_BIT));
        end
      end
      default: begin
        frame_good = 1'b0;
        stage = SEEK_MARK;
      end
    endcase
    if (bit_pos != 8'd255) bit_pos++;
  endtask

  task automatic decode_tick(input logic lvl, input logic [15:0] now, output tick_result_t r);
    logic [15:0] span;
    pulse_ev_t   ev;
    r.loaded = 1'b0;
    if (lvl != line_lvl) begin
      span = now - last_fall;
      if (line_lvl && !lvl) begin
        last_fall = now;
        if (span >= SECOND_LO && span <= SECOND_HI) ev = EV_SECOND;
        else if (span >= MARK_LO && span <= MARK_HI) ev = EV_MINUTE;
        else ev = EV_INVALID;
      end else begin
        if (span >= ZERO_LO && span <= ZERO_HI) ev = EV_ZERO;
        else if (span >= ONE_LO && span <= ONE_HI) ev = EV_ONE;
        else ev = EV_INVALID;
      end
      line_lvl = lvl;
      idle_ticks = 8'd0;
    end else if (idle_ticks > SILENCE_LIMIT) begin
      ev = EV_INVALID;
    end else begin
      idle_ticks++;
      ev = EV_NONE;
    end

    if (ev == EV_MINUTE) begin
      if (frame_good) begin
        wall.year       = 12'd2000 + 12'(acc_year);
        wall.month      = acc_mon;
        wall.month_day  = acc_day;
        wall.week_day   = acc_wday;
        wall.hour       = acc_hour;
        wall.minute     = acc_min;
        wall.utc_offset = acc_zone;
        r.loaded = 1'b1;
      end
      par = 1'b0;
      bit_pos = 8'd0;
      frame_good = 1'b0;
      acc_min = '0;
      acc_hour = '0;
      acc_day = '0;
      acc_wday = '0;
      acc_mon = '0;
      acc_year = '0;
      stage = READ_INFO;
    end else if (ev == EV_INVALID) begin
      frame_good = 1'b0;
      stage = SEEK_MARK;
    end else if (ev == EV_ZERO || ev == EV_ONE) begin
      take_bit(ev == EV_ONE);
    end
    r.ev = ev;
    r.wall = wall;
  endtask

  // Presents one item, waits for its acceptance and records what it must produce.
  task automatic offer(input logic lvl, input logic [15:0] t, input logic typed,
                       input pulse_ev_t typed_ev);
    tick_result_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sig_level <= lvl;
    time_ms   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_tick(lvl, t, r);
    if (typed) r.ev = typed_ev;
    pending_ticks.push_back(r);
    sent_items++;
    @(negedge clk);
  endtask

  // Sends a level change (or a repeat of the level), sometimes after a few quiet ticks.
  task automatic edge_at(input logic lvl, input logic [15:0] t);
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        snd_now = snd_now + 16'd10;
        offer(snd_lvl, snd_now, 1'b0, EV_NONE);
      end
    end
    offer(lvl, t, 1'b0, EV_NONE);
    if (snd_lvl && !lvl) snd_fall = t;
    snd_lvl = lvl;
    snd_now = t;
  endtask

  // Brings the line to a minute mark from whatever state it is in.
  task automatic resync();
    if (!snd_lvl) edge_at(1'b1, snd_now + 16'd100);
    edge_at(1'b0, 16'($urandom));
    edge_at(1'b1, snd_fall + 16'($urandom_range(70, 230)));
    edge_at(1'b0, snd_fall + 16'($urandom_range(1900, 2100)));
  endtask

  // Sends one frame after a minute mark and closes it with the next minute mark.
  task automatic send_frame(input frame_kind_e kind);
    logic [59:0] fb;
    logic [15:0] gap;
    logic [15:0] width;
    int          n_bits;
    int          hit;
    int          k;
    fb = 60'({$urandom, $urandom});
    fb[START_BIT] = 1'b0;
    fb[BEGIN_BIT] = 1'b1;
    fb[CET_BIT:CEST_BIT] = $urandom_range(0, 1) ? 2'b01 : 2'b10;
    fb[MIN_PAR_BIT]  = ^fb[MIN_PAR_BIT-1:MIN_BASE];
    fb[HOUR_PAR_BIT] = ^fb[HOUR_PAR_BIT-1:HOUR_BASE];
    fb[DATE_PAR_BIT] = ^fb[DATE_PAR_BIT-1:DAY_BASE];
    n_bits = 59;
    hit = $urandom_range(1, 57);
    case (kind)
      FR_START_SET: begin
        fb[START_BIT] = 1'b1;
        n_bits = INFO_END + 1 + $urandom_range(0, 3);
      end
      FR_BEGIN_CLEAR: begin
        fb[BEGIN_BIT] = 1'b0;
        n_bits = BEGIN_BIT + 1 + $urandom_range(0, 3);
      end
      FR_MIN_PAR: begin
        fb[MIN_PAR_BIT] = ~fb[MIN_PAR_BIT];
        n_bits = MIN_PAR_BIT + 1 + $urandom_range(0, 3);
      end
      FR_HOUR_PAR: begin
        fb[HOUR_PAR_BIT] = ~fb[HOUR_PAR_BIT];
        n_bits = HOUR_PAR_BIT + 1 + $urandom_range(0, 3);
      end
      FR_DATE_PAR: fb[DATE_PAR_BIT] = ~fb[DATE_PAR_BIT];
      FR_ZONE: fb[CET_BIT:CEST_BIT] = $urandom_range(0, 1) ? 2'b00 : 2'b11;
      FR_GLITCH, FR_SKIP: begin
        n_bits = hit + 1 + $urandom_range(0, 4);
        if (n_bits > 59) n_bits = 59;
      end
      // A leap-second style extra bit keeps the mark from following the parity bit.
      FR_EXTRA: n_bits = 60;
      default: ;
    endcase
    for (k = 0; k < n_bits; k++) begin
      if (k > 0) begin
        if (kind == FR_SKIP && k == hit) gap = 16'($urandom_range(1900, 2100));
        else gap = 16'($urandom_range(900, 1100));
        edge_at(1'b0, snd_fall + gap);
      end
      width = fb[k] ? 16'($urandom_range(170, 230)) : 16'($urandom_range(70, 130));
      if (kind == FR_GLITCH && k == hit) width = 16'($urandom_range(131, 169));
      edge_at(1'b1, snd_fall + width);
    end
    edge_at(1'b0, snd_fall + 16'($urandom_range(1900, 2100)));
    frames_sent++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
      end else begin
        got_exp = pending_ticks.pop_front();
        check_field("pulse_event", got_exp.ev, pulse_event);
        check_field("clock_loaded", got_exp.loaded, clock_loaded);
        check_field("minute", got_exp.wall.minute, minute);
        check_field("hour", got_exp.wall.hour, hour);
        check_field("month_day", got_exp.wall.month_day, month_day);
        check_field("week_day", got_exp.wall.week_day, week_day);
        check_field("month", got_exp.wall.month, month);
        check_field("year", got_exp.wall.year, year);
        check_field("utc_offset", got_exp.wall.utc_offset, utc_offset);
      end
      results_seen++;
      if (clock_loaded) loads_seen++;
      if (pulse_event == EV_INVALID) invalid_seen++;
    end
  end

  // Result side: short random stalls, plus one long hold-off that backs up the input.
  initial begin
    int  hold_left;
    int  stall_left;
    bit  held_once;
    hold_left = 0;
    stall_left = 0;
    held_once = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int          idx;
    int          frame_no;
    frame_kind_e kind;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (idx = 0; idx < DRILL_ROWS; idx++) begin
      repeat (DRILLS[idx].reps) begin
        offer(DRILLS[idx].lvl, DRILLS[idx].t, DRILLS[idx].typed, DRILLS[idx].ev);
      end
    end
    // The last silence tick reports invalid; the one before it is still quiet.

    // Let the block drain completely before the framed traffic starts.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_ticks.size() != 0) @(negedge clk);

    snd_lvl  = DRILLS[DRILL_ROWS-1].lvl;
    snd_fall = 16'hFFFF;
    snd_now  = DRILLS[DRILL_ROWS-1].t;
    resync();
    frame_no = 0;
    while (frame_no < CYCLE_LEN || sent_items < ITEM_TARGET) begin
      if (frame_no < CYCLE_LEN) kind = KIND_CYCLE[frame_no];
      else if ($urandom_range(0, 1) == 1) kind = FR_GOOD;
      else kind = frame_kind_e'($urandom_range(0, FR_NOISE));
      if (frame_no >= CYCLE_LEN - 1 && sent_items >= ITEM_TARGET - 150) calm = 1'b1;
      if (kind == FR_NOISE) begin
        repeat ($urandom_range(10, 30)) edge_at(1'($urandom_range(0, 1)), 16'($urandom));
        resync();
      end else begin
        send_frame(kind);
      end
      frame_no++;
    end
    in_valid <= 1'b0;

    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("%0d ticks sent, %0d results checked, %0d frames framed by minute marks,",
             sent_items, results_seen, frames_sent);
    $display("%0d clock loads and %0d invalid pulses seen.", loads_seen, invalid_seen);
    if (errors == 0) begin
      $display("dcf77_time_code_decoder_core_test: done, clean");
    end else begin
      $display("dcf77_time_code_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
